[hdl/stbm_pkg.sv]
package stbm_pkg;

  // Shared divider geometry: the dividend is left-aligned in a 44-bit word and
  // retired four quotient bits per cycle against a 12-bit divisor.
  localparam int unsigned DivNumW        = 44;
  localparam int unsigned DivDenW        = 12;
  localparam int unsigned DigitsPerCycle = 4;
  localparam int unsigned DivCntW        = 4;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] dividend;
    logic [DivDenW-1:0] divisor;
    logic [DivCntW-1:0] cycles;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DivNumW-1:0] quot;
  } div_rsp_t;

endpackage

[hdl/stbm_div.sv]
module stbm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stbm_pkg::div_req_t req_i,
  output stbm_pkg::div_rsp_t rsp_o
);

  logic                                  busy_q;
  logic                                  done_q;
  logic [stbm_pkg::DivCntW-1:0]          cnt_q;
  logic [stbm_pkg::DivDenW-1:0]          rem_q, rem_d;
  logic [stbm_pkg::DivNumW-1:0]          dq_q, dq_d;
  logic [stbm_pkg::DivDenW-1:0]          dvs_q;
  logic [stbm_pkg::DivDenW:0]            trial;

  // Restoring division, several digits per cycle. The quotient bits enter at
  // the bottom of the dividend register as the dividend bits leave the top.
  always_comb begin
    rem_d = rem_q;
    dq_d  = dq_q;
    trial = '0;
    for (int i = 0; i < stbm_pkg::DigitsPerCycle; i++) begin
      trial = {rem_d, dq_d[stbm_pkg::DivNumW-1]};
      dq_d  = {dq_d[stbm_pkg::DivNumW-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d    = stbm_pkg::DivDenW'(trial - {1'b0, dvs_q});
        dq_d[0]  = 1'b1;
      end else begin
        rem_d = trial[stbm_pkg::DivDenW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.cycles;
    end else if (busy_q) begin
      cnt_q <= cnt_q - stbm_pkg::DivCntW'(1);
      if (cnt_q == stbm_pkg::DivCntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dq_q  <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dq_q  <= dq_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dq_q;

endmodule

[hdl/supply_temp_battery_monitor.sv]
// Supply, die temperature and battery monitor. One beat of three 12-bit ADC
// samples yields supply millivolts, die temperature in milli-degrees, battery
// millivolts, battery level in permille and the status flags. The block works
// on one beat at a time: a small sequencer steps through up to five divisions
// on one shared divider that retires four quotient bits per cycle, fed by one
// shared multiplier. The level division is skipped when the battery level is
// clamped. The temperature divisions are skipped when the temperature cannot
// be computed: for a zero reference sample (which also skips the supply
// division), a zero supply or equal temperature calibrations. A result still
// waiting in the output register holds the next one back until it is taken.
// The input is ready again in the cycle after the result is loaded into the
// output register, even if that result has not been taken yet. Calibration
// registers are written through a separate write channel that is always ready.
module supply_temp_battery_monitor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [11:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [11:0]        vref_raw_i,
  input  logic [11:0]        temp_raw_i,
  input  logic [11:0]        vbat_raw_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [23:0]        vcc_mv_o,
  output logic signed [31:0] temperature_millic_o,
  output logic [25:0]        vbat_mv_o,
  output logic [9:0]         battery_permille_o,
  output logic               voltage_unstable_o,
  output logic               over_temp_o,
  output logic               critical_battery_o,
  output logic               low_battery_o,
  output logic               fault_o
);

  localparam logic [1:0] RegVrefCal     = 2'd0;
  localparam logic [1:0] RegTempCalLow  = 2'd1;
  localparam logic [1:0] RegTempCalHigh = 2'd2;

  localparam logic [stbm_pkg::DivCntW-1:0] CycVcc = 4'd6;
  localparam logic [stbm_pkg::DivCntW-1:0] CycScl = 4'd9;
  localparam logic [stbm_pkg::DivCntW-1:0] CycTmp = 4'd11;
  localparam logic [stbm_pkg::DivCntW-1:0] CycVb  = 4'd10;
  localparam logic [stbm_pkg::DivCntW-1:0] CycLvl = 4'd6;

  localparam logic signed [42:0] TempOffset = 43'sd30000;
  localparam logic signed [42:0] TempSatMax = 43'sd2147483647;
  localparam logic signed [42:0] TempSatMin = -43'sd2147483648;

  typedef enum logic [3:0] {
    S_IDLE, S_VCC_MUL, S_VCC_DIV, S_SCL_MUL, S_SCL_DIV, S_TMP_MUL, S_TMP_DIV,
    S_VB_MUL, S_VB_DIV, S_LVL, S_LVL_DIV, S_DONE
  } state_e;

  state_e state_q;

  logic [11:0] vref_cal_q, temp_cal_low_q, temp_cal_high_q;
  logic [11:0] vref_q, traw_q, braw_q;
  logic [23:0] vcc_q;
  logic [23:0] scaled_q;
  logic        neg_q;
  logic signed [31:0] temp_q;
  logic [25:0] vbat_q;
  logic [9:0]  level_q;
  logic        unstable_q, overtemp_q;

  logic               out_valid_q;
  logic [23:0]        out_vcc_q;
  logic signed [31:0] out_temp_q;
  logic [25:0]        out_vbat_q;
  logic [9:0]         out_level_q;
  logic               out_unstable_q, out_over_q, out_crit_q, out_low_q, out_fault_q;

  stbm_pkg::div_req_t div_req;
  stbm_pkg::div_rsp_t div_rsp;

  logic [25:0] mul_a;
  logic [16:0] mul_b;
  logic [42:0] prod;

  logic signed [12:0] span;
  logic [11:0]        span_mag;
  logic signed [24:0] diff;
  logic [23:0]        diff_mag;
  logic signed [42:0] tmag, tsum;
  logic signed [31:0] temp_sat;
  logic               crit, low;

  assign span     = signed'({1'b0, temp_cal_high_q}) - signed'({1'b0, temp_cal_low_q});
  assign span_mag = span[12] ? 12'(-span) : span[11:0];
  assign diff     = signed'({1'b0, scaled_q}) - signed'({13'b0, temp_cal_low_q});
  assign diff_mag = diff[24] ? 24'(-diff) : diff[23:0];

  // Shared multiplier; its product goes straight into the divider register.
  always_comb begin
    case (state_q)
      S_VCC_MUL: begin
        mul_a = {14'b0, vref_cal_q};
        mul_b = 17'd3000;
      end
      S_SCL_MUL: begin
        mul_a = {2'b0, vcc_q};
        mul_b = {5'b0, traw_q};
      end
      S_TMP_MUL: begin
        mul_a = {2'b0, diff_mag};
        mul_b = 17'd80000;
      end
      S_VB_MUL: begin
        mul_a = {2'b0, vcc_q};
        mul_b = {4'b0, braw_q, 1'b0} + {5'b0, braw_q};
      end
      S_LVL: begin
        mul_a = vbat_q - 26'd3000;
        mul_b = 17'd1000;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = 43'(mul_a) * 43'(mul_b);

  // Each dividend is left-aligned so that only its significant digits are
  // walked through.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    div_req.cycles   = '0;
    case (state_q)
      S_VCC_MUL: begin
        div_req.start    = 1'b1;
        div_req.dividend = {1'b0, prod} << 20;
        div_req.divisor  = vref_q;
        div_req.cycles   = CycVcc;
      end
      S_SCL_MUL: begin
        div_req.start    = 1'b1;
        div_req.dividend = {1'b0, prod} << 8;
        div_req.divisor  = 12'd3000;
        div_req.cycles   = CycScl;
      end
      S_TMP_MUL: begin
        div_req.start    = 1'b1;
        div_req.dividend = {1'b0, prod};
        div_req.divisor  = span_mag;
        div_req.cycles   = CycTmp;
      end
      S_VB_MUL: begin
        div_req.start    = 1'b1;
        div_req.dividend = {1'b0, prod} << 4;
        div_req.divisor  = 12'd4095;
        div_req.cycles   = CycVb;
      end
      S_LVL: begin
        div_req.start    = (vbat_q < 26'd4200) && (vbat_q > 26'd3000);
        div_req.dividend = {1'b0, prod} << 20;
        div_req.divisor  = 12'd1200;
        div_req.cycles   = CycLvl;
      end
      default: ;
    endcase
  end

  stbm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Division truncates toward zero, so the sign is applied to the magnitude.
  always_comb begin
    tmag = signed'({2'b0, div_rsp.quot[40:0]});
    tsum = (neg_q ? -tmag : tmag) + TempOffset;
    if (tsum > TempSatMax) begin
      temp_sat = 32'sh7FFFFFFF;
    end else if (tsum < TempSatMin) begin
      temp_sat = 32'sh80000000;
    end else begin
      temp_sat = tsum[31:0];
    end
  end

  assign crit = level_q < 10'd50;
  assign low  = level_q < 10'd150;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      vref_cal_q      <= 12'd1655;
      temp_cal_low_q  <= 12'd1034;
      temp_cal_high_q <= 12'd1370;
      unstable_q      <= 1'b0;
      overtemp_q      <= 1'b0;
      vref_q          <= '0;
      traw_q          <= '0;
      braw_q          <= '0;
      vcc_q           <= '0;
      scaled_q        <= '0;
      neg_q           <= 1'b0;
      temp_q          <= '0;
      vbat_q          <= '0;
      level_q         <= '0;
      out_valid_q     <= 1'b0;
      out_vcc_q       <= '0;
      out_temp_q      <= '0;
      out_vbat_q      <= '0;
      out_level_q     <= '0;
      out_unstable_q  <= 1'b0;
      out_over_q      <= 1'b0;
      out_crit_q      <= 1'b0;
      out_low_q       <= 1'b0;
      out_fault_q     <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegVrefCal:     vref_cal_q      <= cfg_data_i;
          RegTempCalLow:  temp_cal_low_q  <= cfg_data_i;
          RegTempCalHigh: temp_cal_high_q <= cfg_data_i;
          default: ;
        endcase
      end

      // In the done state the output register is reloaded below instead.
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            vref_q <= vref_raw_i;
            traw_q <= temp_raw_i;
            braw_q <= vbat_raw_i;
            vcc_q  <= '0;
            temp_q <= '0;
            if (vref_raw_i == 12'd0) begin
              state_q <= S_VB_MUL;
            end else begin
              state_q <= S_VCC_MUL;
            end
          end
        end
        S_VCC_MUL: state_q <= S_VCC_DIV;
        S_VCC_DIV: begin
          if (div_rsp.done) begin
            vcc_q      <= div_rsp.quot[23:0];
            unstable_q <= (div_rsp.quot[23:0] < 24'd3000) ||
                          (div_rsp.quot[23:0] > 24'd3600);
            if ((div_rsp.quot[23:0] != 24'd0) && (span != 13'sd0)) begin
              state_q <= S_SCL_MUL;
            end else begin
              state_q <= S_VB_MUL;
            end
          end
        end
        S_SCL_MUL: state_q <= S_SCL_DIV;
        S_SCL_DIV: begin
          if (div_rsp.done) begin
            scaled_q <= div_rsp.quot[23:0];
            state_q  <= S_TMP_MUL;
          end
        end
        S_TMP_MUL: begin
          neg_q   <= diff[24] ^ span[12];
          state_q <= S_TMP_DIV;
        end
        S_TMP_DIV: begin
          if (div_rsp.done) begin
            temp_q     <= temp_sat;
            overtemp_q <= temp_sat > 32'sd80000;
            state_q    <= S_VB_MUL;
          end
        end
        S_VB_MUL: state_q <= S_VB_DIV;
        S_VB_DIV: begin
          if (div_rsp.done) begin
            vbat_q  <= div_rsp.quot[25:0];
            state_q <= S_LVL;
          end
        end
        S_LVL: begin
          if (vbat_q >= 26'd4200) begin
            level_q <= 10'd1000;
            state_q <= S_DONE;
          end else if (vbat_q <= 26'd3000) begin
            level_q <= 10'd0;
            state_q <= S_DONE;
          end else begin
            state_q <= S_LVL_DIV;
          end
        end
        S_LVL_DIV: begin
          if (div_rsp.done) begin
            level_q <= div_rsp.quot[9:0];
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q    <= 1'b1;
            out_vcc_q      <= vcc_q;
            out_temp_q     <= temp_q;
            out_vbat_q     <= vbat_q;
            out_level_q    <= level_q;
            out_unstable_q <= unstable_q;
            out_over_q     <= overtemp_q;
            out_crit_q     <= crit;
            out_low_q      <= low;
            out_fault_q    <= unstable_q | overtemp_q | crit | low;
            state_q        <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready_o          = 1'b1;
  assign in_ready_o           = (state_q == S_IDLE);
  assign out_valid_o          = out_valid_q;
  assign vcc_mv_o             = out_vcc_q;
  assign temperature_millic_o = out_temp_q;
  assign vbat_mv_o            = out_vbat_q;
  assign battery_permille_o   = out_level_q;
  assign voltage_unstable_o   = out_unstable_q;
  assign over_temp_o          = out_over_q;
  assign critical_battery_o   = out_crit_q;
  assign low_battery_o        = out_low_q;
  assign fault_o              = out_fault_q;

endmodule
